// ===== rtl/i2cras_pkg.sv =====
package i2cras_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;
  localparam int FUNC_W = 3;
  localparam int DEV_W = 7;
  localparam int BYTE_W = 8;
  localparam int COUNT_W = 6;
  localparam int IDX_W = 5;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 3'd0,
    FN_WRITE  = 3'd1,
    FN_READ   = 3'd2,
    FN_TXRDY  = 3'd3,
    FN_RXBYTE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_REG  = 3'd1,
    M_TURN = 3'd2,
    M_RX   = 3'd3,
    M_TX   = 3'd4
  } mode_t;

  // Declared from the highest field down so that send_valid lands in bit 0.
  typedef struct packed {
    logic              busy_res;
    logic              done_res;
    logic [IDX_W-1:0]  got_index;
    logic [BYTE_W-1:0] got_byte;
    logic              got_valid;
    logic              receive_dir;
    logic              stop_cond;
    logic              start_cond;
    logic [DEV_W-1:0]  slave_addr;
    logic [BYTE_W-1:0] send_byte;
    logic              send_valid;
  } res_t;

endpackage

// ===== rtl/i2c_register_access_sequencer.sv =====
// A result item passes through the s1 register and then the output register
// after its input item is accepted.
// Throughput: one item per cycle while the output side takes results; the state
// update and the write-byte store read are issued in the accept cycle, and the
// store read data is merged in front of the output register as the item leaves s1.
// Reset: synchronous, active low; returns to idle with all counters cleared.
// The write-byte store is not cleared and holds its contents until written.
module i2c_register_access_sequencer import i2cras_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // slave address, register address, count, data from the lowest bit up.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func.
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // send_valid, send_byte, slave_addr, start_cond, stop_cond, receive_dir,
  // got_valid, got_byte, got_index, done_res, busy_res from the lowest bit up.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic              step;
  res_t              res_c;
  res_t              res_q;
  logic              use_mem;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  assign step = in_tvalid && in_tready;

  i2cras_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .func     (in_tuser),
    .dev_id   (in_tdata[6:0]),
    .reg_byte (in_tdata[14:7]),
    .count    (in_tdata[20:15]),
    .data     (in_tdata[28:21]),
    .res      (res_c),
    .use_mem  (use_mem),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr)
  );

  i2cras_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUFFER_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  i2cras_ostage u_ostage (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .res_in   (res_c),
    .use_mem  (use_mem),
    .mem_rdata(mem_rdata),
    .ready    (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .res_out  (res_q)
  );

  assign out_tdata = {(OUT_TDATA_W - $bits(res_t))'(0), res_q};

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the output side can drain");

  a_send_got_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res_q.send_valid && res_q.got_valid))
    else $error("transmit and receive byte in the same item");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_q.done_res) |-> !res_q.busy_res)
    else $error("done flagged while still busy");

  a_rx_dir_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_q.receive_dir) |-> res_q.busy_res)
    else $error("receive direction outside a transaction");
`endif

endmodule

// ===== rtl/i2cras_ram.sv =====
module i2cras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/i2cras_ctrl.sv =====
module i2cras_ctrl import i2cras_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [FUNC_W-1:0]  func,
  input  logic [DEV_W-1:0]   dev_id,
  input  logic [BYTE_W-1:0]  reg_byte,
  input  logic [COUNT_W-1:0] count,
  input  logic [BYTE_W-1:0]  data,
  output res_t               res,
  output logic               use_mem,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [BYTE_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr
);

  localparam int RXW = (AW > IDX_W) ? AW : IDX_W;

  mode_t              mode_r, mode_nxt;
  logic [BYTE_W-1:0]  addr_r, addr_nxt;
  logic [DEV_W-1:0]   dev_r, dev_nxt;
  logic [COUNT_W-1:0] tx_left_r, tx_left_nxt;
  logic [COUNT_W-1:0] rx_left_r, rx_left_nxt;
  logic [AW-1:0]      tx_pos_r, tx_pos_nxt;
  logic [RXW-1:0]     rx_pos_r, rx_pos_nxt;
  logic [AW-1:0]      load_pos_r, load_pos_nxt;
  logic [COUNT_W-1:0] count_c;
  func_t              fn;

  assign fn = func_t'(func);
  assign count_c = (int'(count) > BUFFER_DEPTH) ? COUNT_W'(BUFFER_DEPTH) : count;

  always_comb begin
    mode_nxt = mode_r;
    case (fn)
      FN_WRITE, FN_READ: begin
        if (mode_r == M_IDLE) begin
          mode_nxt = M_REG;
        end
      end
      FN_TXRDY: begin
        case (mode_r)
          M_REG:   mode_nxt = (rx_left_r != '0) ? M_TURN : M_TX;
          M_TURN:  mode_nxt = M_RX;
          M_TX:    mode_nxt = (tx_left_r != '0) ? M_TX : M_IDLE;
          default: mode_nxt = mode_r;
        endcase
      end
      FN_RXBYTE: begin
        if (mode_r == M_RX && rx_left_nxt == '0) begin
          mode_nxt = M_IDLE;
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  always_comb begin
    logic [COUNT_W-1:0] rl;
    rl = rx_left_r;
    addr_nxt = addr_r;
    dev_nxt = dev_r;
    tx_left_nxt = tx_left_r;
    rx_left_nxt = rx_left_r;
    tx_pos_nxt = tx_pos_r;
    rx_pos_nxt = rx_pos_r;
    load_pos_nxt = load_pos_r;
    res = '0;
    use_mem = 1'b0;
    mem_we = 1'b0;
    case (fn)
      FN_LOAD: begin
        if (mode_r == M_IDLE) begin
          mem_we = step;
          load_pos_nxt = (load_pos_r == AW'(BUFFER_DEPTH - 1)) ? '0 : load_pos_r + 1'b1;
        end
      end
      FN_WRITE, FN_READ: begin
        if (mode_r == M_IDLE) begin
          addr_nxt = reg_byte;
          dev_nxt = dev_id;
          tx_pos_nxt = '0;
          rx_pos_nxt = '0;
          load_pos_nxt = '0;
          tx_left_nxt = (fn == FN_WRITE) ? count_c : '0;
          rx_left_nxt = (fn == FN_WRITE) ? '0 : count_c;
          res.start_cond = 1'b1;
        end
      end
      FN_TXRDY: begin
        case (mode_r)
          M_REG: begin
            res.send_valid = 1'b1;
            res.send_byte = addr_r;
          end
          M_TURN: begin
            res.start_cond = 1'b1;
            res.stop_cond = (rx_left_r == COUNT_W'(1));
          end
          M_TX: begin
            if (tx_left_r != '0) begin
              res.send_valid = 1'b1;
              use_mem = 1'b1;
              tx_pos_nxt = (tx_pos_r == AW'(BUFFER_DEPTH - 1)) ? '0 : tx_pos_r + 1'b1;
              tx_left_nxt = tx_left_r - 1'b1;
            end else begin
              res.stop_cond = 1'b1;
              res.done_res = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      FN_RXBYTE: begin
        if (mode_r == M_RX) begin
          if (rl != '0) begin
            res.got_valid = 1'b1;
            res.got_byte = data;
            res.got_index = rx_pos_r[IDX_W-1:0];
            rx_pos_nxt = (rx_pos_r == RXW'(BUFFER_DEPTH - 1)) ? '0 : rx_pos_r + 1'b1;
            rl = rl - 1'b1;
          end
          rx_left_nxt = rl;
          if (rl == COUNT_W'(1)) begin
            res.stop_cond = 1'b1;
          end else if (rl == '0) begin
            res.done_res = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.slave_addr = dev_nxt;
    res.receive_dir = (mode_nxt == M_RX);
    res.busy_res = (mode_nxt != M_IDLE);
  end

  assign mem_waddr = load_pos_r;
  assign mem_wdata = data;
  assign mem_re = step && use_mem;
  assign mem_raddr = tx_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      addr_r <= '0;
      dev_r <= '0;
      tx_left_r <= '0;
      rx_left_r <= '0;
      tx_pos_r <= '0;
      rx_pos_r <= '0;
      load_pos_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      addr_r <= addr_nxt;
      dev_r <= dev_nxt;
      tx_left_r <= tx_left_nxt;
      rx_left_r <= rx_left_nxt;
      tx_pos_r <= tx_pos_nxt;
      rx_pos_r <= rx_pos_nxt;
      load_pos_r <= load_pos_nxt;
    end
  end

endmodule

// ===== rtl/i2cras_ostage.sv =====
module i2cras_ostage import i2cras_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  res_t              res_in,
  input  logic              use_mem,
  input  logic [BYTE_W-1:0] mem_rdata,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              res_out
);

  logic s1_v_r;
  logic s1_mem_r;
  res_t s1_r;
  logic out_v_r;
  res_t out_r;
  logic advance;
  res_t merged;

  assign advance = s1_v_r && (!out_v_r || out_ready);
  assign ready = !s1_v_r || advance;
  assign out_valid = out_v_r;
  assign res_out = out_r;

  always_comb begin
    merged = s1_r;
    if (s1_mem_r) begin
      merged.send_byte = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (step) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_r <= res_in;
      s1_mem_r <= use_mem;
    end
    if (advance) begin
      out_r <= merged;
    end
  end

endmodule

// ===== tb/i2c_register_access_sequencer_tb.sv =====
`timescale 1ns / 1ps

module i2c_register_access_sequencer_tb;
  import i2cras_pkg::*;

  localparam int ITEMS = 1900;
  localparam int DEPTH = BUFFER_DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FN_RESERVED = 3'd7;

  class i2c_seq_scoreboard;
    mode_t            mode;
    logic [7:0]       addr_byte;
    logic [5:0]       tx_left;
    logic [5:0]       rx_left;
    logic [4:0]       tx_pos;
    logic [4:0]       rx_pos;
    logic [4:0]       load_pos;
    logic [6:0]       held_dev;
    logic [7:0]       wr_bytes[DEPTH];
    bit               loaded[DEPTH];
    res_t             expected_q[$];
    int               errors;
    int               accepted;
    int               acted;
    int               checked;
    int               completed;
    int               received;

    function new();
      mode = M_IDLE;
      addr_byte = '0;
      tx_left = '0;
      rx_left = '0;
      tx_pos = '0;
      rx_pos = '0;
      load_pos = '0;
      held_dev = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      errors = 0;
      accepted = 0;
      acted = 0;
      checked = 0;
      completed = 0;
      received = 0;
    endfunction

    function int loaded_prefix();
      int n;
      n = 0;
      while (n < DEPTH && loaded[n]) n++;
      return n;
    endfunction

    function logic [5:0] clamp_count(logic [5:0] c);
      return (c > DEPTH) ? 6'(DEPTH) : c;
    endfunction

    function void note_item(logic [2:0] fn, logic [6:0] dev, logic [7:0] regb,
                            logic [5:0] cnt, logic [7:0] data);
      res_t r;
      bit   act;
      r = '0;
      act = 1'b0;
      accepted++;
      case (fn)
        FN_LOAD: begin
          if (mode == M_IDLE) begin
            wr_bytes[load_pos] = data;
            loaded[load_pos] = 1'b1;
            load_pos = 5'((load_pos + 1) % DEPTH);
            act = 1'b1;
          end
        end
        FN_WRITE, FN_READ: begin
          if (mode == M_IDLE) begin
            mode = M_REG;
            addr_byte = regb;
            held_dev = dev;
            tx_pos = '0;
            rx_pos = '0;
            load_pos = '0;
            if (fn == FN_WRITE) begin
              tx_left = clamp_count(cnt);
              rx_left = '0;
            end else begin
              rx_left = clamp_count(cnt);
              tx_left = '0;
            end
            r.start_cond = 1'b1;
            act = 1'b1;
          end
        end
        FN_TXRDY: begin
          act = 1'b1;
          if (mode == M_REG) begin
            r.send_valid = 1'b1;
            r.send_byte = addr_byte;
            mode = (rx_left != 0) ? M_TURN : M_TX;
          end else if (mode == M_TURN) begin
            r.start_cond = 1'b1;
            mode = M_RX;
            if (rx_left == 1) r.stop_cond = 1'b1;
          end else if (mode == M_TX) begin
            if (tx_left != 0) begin
              r.send_valid = 1'b1;
              r.send_byte = wr_bytes[tx_pos];
              tx_pos = 5'((tx_pos + 1) % DEPTH);
              tx_left--;
            end else begin
              r.stop_cond = 1'b1;
              mode = M_IDLE;
              r.done_res = 1'b1;
            end
          end else begin
            act = 1'b0;
          end
        end
        FN_RXBYTE: begin
          if (mode == M_RX) begin
            act = 1'b1;
            if (rx_left != 0) begin
              r.got_valid = 1'b1;
              r.got_byte = data;
              r.got_index = rx_pos;
              rx_pos = 5'((rx_pos + 1) % DEPTH);
              rx_left--;
              received++;
            end
            if (rx_left == 1) begin
              r.stop_cond = 1'b1;
            end else if (rx_left == 0) begin
              mode = M_IDLE;
              r.done_res = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.slave_addr = held_dev;
      r.receive_dir = (mode == M_RX);
      r.busy_res = (mode != M_IDLE);
      if (r.done_res) completed++;
      if (act) acted++;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("send_valid", e.send_valid, got.send_valid);
      cmp_field("send_byte", e.send_byte, got.send_byte);
      cmp_field("slave_addr", e.slave_addr, got.slave_addr);
      cmp_field("start_cond", e.start_cond, got.start_cond);
      cmp_field("stop_cond", e.stop_cond, got.stop_cond);
      cmp_field("receive_dir", e.receive_dir, got.receive_dir);
      cmp_field("got_valid", e.got_valid, got.got_valid);
      cmp_field("got_byte", e.got_byte, got.got_byte);
      cmp_field("got_index", e.got_index, got.got_index);
      cmp_field("done_res", e.done_res, got.done_res);
      cmp_field("busy_res", e.busy_res, got.busy_res);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  i2c_seq_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  i2c_register_access_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_item(in_tuser, in_tdata[6:0], in_tdata[14:7], in_tdata[20:15], in_tdata[28:21]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(res_t'(out_tdata[$bits(res_t)-1:0]));
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("i2c_register_access_sequencer_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // A long hold lets the pipeline fill so that in_tready drops.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Called and returning on a falling edge, after the last accept was noted.
  task automatic send_item(logic [2:0] fn, logic [6:0] dev, logic [7:0] regb,
                           logic [5:0] cnt, logic [7:0] data);
    int room;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    room = sb.loaded_prefix();
    if (fn == FN_WRITE && sb.mode == M_IDLE && sb.clamp_count(cnt) > room) begin
      cnt = 6'($urandom_range(room));
    end
    in_tuser <= fn;
    in_tdata <= {3'b000, data, cnt, regb, dev};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic random_item();
    send_item(3'($urandom_range(7)), 7'($urandom_range(127)), 8'($urandom),
              6'($urandom), 8'($urandom));
  endtask

  task automatic bus_item(logic [2:0] fn, logic [5:0] cnt);
    if ($urandom_range(99) < 4) random_item();
    send_item(fn, 7'($urandom_range(127)), 8'($urandom), cnt, 8'($urandom));
  endtask

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 6'd0;
    if (r < 75) return 6'($urandom_range(1, 4));
    if (r < 93) return 6'($urandom_range(5, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  task automatic finish_transfer();
    int n;
    n = 0;
    while (sb.mode != M_IDLE && n < 80) begin
      if (sb.mode == M_RX) bus_item(FN_RXBYTE, 6'($urandom));
      else bus_item(FN_TXRDY, 6'($urandom));
      n++;
    end
  endtask

  task automatic run_transfer();
    int kind;
    int nloads;
    kind = $urandom_range(99);
    if (kind < 45) begin
      nloads = ($urandom_range(7) == 0) ? $urandom_range(32, 40) : $urandom_range(6);
      repeat (nloads) bus_item(FN_LOAD, 6'($urandom));
      bus_item(FN_WRITE, pick_count());
      finish_transfer();
    end else if (kind < 90) begin
      bus_item(FN_READ, pick_count());
      finish_transfer();
    end else begin
      repeat ($urandom_range(1, 4)) random_item();
    end
  endtask

  initial begin
    int base;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_item(FN_RESERVED, 7'h7f, 8'hff, 6'h3f, 8'hff);
    send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_RXBYTE, 7'h00, 8'h00, 6'h00, 8'hff);
    send_item(FN_LOAD, 7'h00, 8'h00, 6'h00, 8'hff);
    send_item(FN_LOAD, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_WRITE, 7'h7f, 8'hff, 6'd2, 8'h00);
    repeat (4) send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_READ, 7'h00, 8'h00, 6'd1, 8'h00);
    send_item(FN_LOAD, 7'h00, 8'h00, 6'h00, 8'h5a);
    send_item(FN_WRITE, 7'h11, 8'h22, 6'd1, 8'h00);
    send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_RXBYTE, 7'h00, 8'h00, 6'h00, 8'h33);
    send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_RXBYTE, 7'h00, 8'h00, 6'h00, 8'hff);
    send_item(FN_READ, 7'h2a, 8'h80, 6'd0, 8'h00);
    repeat (2) send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);
    send_item(FN_WRITE, 7'h55, 8'h01, 6'd0, 8'h00);
    repeat (2) send_item(FN_TXRDY, 7'h00, 8'h00, 6'h00, 8'h00);

    base = sb.acted;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph == 0 || ph == 2) hold_reqs++;
      while (sb.acted < base + (ph + 1) * ITEMS / 4) run_transfer();
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Accepted %0d input items, %0d of them acting on the sequencer state.",
             sb.accepted, sb.acted);
    $display("Checked %0d result items; %0d transfers completed, %0d bytes received.",
             sb.checked, sb.completed, sb.received);
    if (sb.errors == 0) begin
      $display("i2c_register_access_sequencer_tb: done, clean");
    end else begin
      $display("i2c_register_access_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2cras_pkg.sv
rtl/i2cras_ram.sv
rtl/i2cras_ctrl.sv
rtl/i2cras_ostage.sv
rtl/i2c_register_access_sequencer.sv
tb/i2c_register_access_sequencer_tb.sv
